@@ rtl/ppmfd_pkg.sv @@
// ----------------------------------------------------------------------------
// ppmfd_pkg
// Shared constants, register codes and types of the PPM frame decoder.
// ----------------------------------------------------------------------------
package ppmfd_pkg;

    // Channel store depth and publishing limits
    localparam int MAX_CHANNELS = 16;
    localparam int RESULT_LIMIT = 16;

    // Field widths
    localparam int TIME_W  = 32;
    localparam int WIDTH_W = 16;
    localparam int IDX_W   = 4;
    localparam int EXP_W   = 5;

    // Channel counter holds 0 .. MAX_CHANNELS + 1
    localparam int CNT_W   = $clog2(MAX_CHANNELS + 2);
    // Rotation step counter runs 0 .. MAX_CHANNELS - 1
    localparam int STEP_W  = $clog2(MAX_CHANNELS);
    // Width wide enough to compare the counter with the expected count
    localparam int CMP_W   = (CNT_W > EXP_W) ? CNT_W : EXP_W;

    // APB port
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    // Register indexes
    typedef enum logic [1:0] {
        REG_SYNC_GAP   = 2'd0,
        REG_PULSE_LOW  = 2'd1,
        REG_PULSE_HIGH = 2'd2,
        REG_EXPECTED   = 2'd3
    } t_reg_idx;

    // Register reset values
    localparam logic [WIDTH_W-1:0] SYNC_GAP_RST   = 16'd10000;
    localparam logic [WIDTH_W-1:0] PULSE_LOW_RST  = 16'd1050;
    localparam logic [WIDTH_W-1:0] PULSE_HIGH_RST = 16'd1950;
    localparam logic [EXP_W-1:0]   EXPECTED_RST   = 5'd8;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [WIDTH_W-1:0] sync_gap_min;
        logic [WIDTH_W-1:0] pulse_low_limit;
        logic [WIDTH_W-1:0] pulse_high_limit;
        logic [EXP_W-1:0]   expected_channels;
    } t_cfg;

    // Control shared by every cell of the width ring
    typedef struct packed {
        logic               shift;
        logic               store;
        logic [WIDTH_W-1:0] store_width;
    } t_cell_ctrl;

endpackage

@@ rtl/ppmfd_if.sv @@
// ----------------------------------------------------------------------------
// ppmfd_if
// Valid/ready channels of the PPM frame decoder: edge items in, channel
// items out.
// ----------------------------------------------------------------------------
interface ppmfd_in_if;
    logic                              valid;
    logic                              ready;
    logic [ppmfd_pkg::TIME_W-1:0]      edge_time;

    modport source (output valid, output edge_time, input ready);
    modport sink   (input valid, input edge_time, output ready);
endinterface

interface ppmfd_out_if;
    logic                              valid;
    logic                              ready;
    logic [ppmfd_pkg::IDX_W-1:0]       channel_index;
    logic [ppmfd_pkg::WIDTH_W-1:0]     channel_width;
    logic                              frame_last;

    modport source (output valid, output channel_index, output channel_width,
                    output frame_last, input ready);
    modport sink   (input valid, input channel_index, input channel_width,
                    input frame_last, output ready);
endinterface

@@ rtl/ppmfd_cell.sv @@
// ----------------------------------------------------------------------------
// ppmfd_cell
// One slot of the channel width ring: stores a width when selected, or takes
// its neighbour's width while the ring rotates.
// ----------------------------------------------------------------------------
module ppmfd_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ppmfd_pkg::t_cell_ctrl              i_ctrl,
    input  logic                               i_sel,
    input  logic [ppmfd_pkg::WIDTH_W-1:0]      i_shift_in,
    output logic [ppmfd_pkg::WIDTH_W-1:0]      o_width
);

    logic [ppmfd_pkg::WIDTH_W-1:0] r_width;
    logic [ppmfd_pkg::WIDTH_W-1:0] n_width;

    // Rotate takes priority; otherwise capture a new width for this slot
    always_comb begin
        n_width = r_width;
        if (i_ctrl.shift) begin
            n_width = i_shift_in;
        end else if (i_ctrl.store && i_sel) begin
            n_width = i_ctrl.store_width;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= '0;
        end else begin
            r_width <= n_width;
        end
    end

    assign o_width = r_width;

endmodule

@@ rtl/ppmfd_regs.sv @@
// ----------------------------------------------------------------------------
// ppmfd_regs
// APB register file: sync gap, pulse window and expected channel count.
// ----------------------------------------------------------------------------
module ppmfd_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ppmfd_pkg::APB_AW-1:0]       paddr,
    input  logic [ppmfd_pkg::APB_DW-1:0]       pwdata,
    output logic [ppmfd_pkg::APB_DW-1:0]       prdata,
    output logic                               pready,
    output ppmfd_pkg::t_cfg                    o_cfg
);

    ppmfd_pkg::t_cfg      r_cfg;
    ppmfd_pkg::t_cfg      n_cfg;
    ppmfd_pkg::t_reg_idx  reg_idx;
    logic                 wr_en;

    assign reg_idx = ppmfd_pkg::t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Decode the write
    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                ppmfd_pkg::REG_SYNC_GAP: begin
                    n_cfg.sync_gap_min = pwdata[ppmfd_pkg::WIDTH_W-1:0];
                end
                ppmfd_pkg::REG_PULSE_LOW: begin
                    n_cfg.pulse_low_limit = pwdata[ppmfd_pkg::WIDTH_W-1:0];
                end
                ppmfd_pkg::REG_PULSE_HIGH: begin
                    n_cfg.pulse_high_limit = pwdata[ppmfd_pkg::WIDTH_W-1:0];
                end
                ppmfd_pkg::REG_EXPECTED: begin
                    n_cfg.expected_channels = pwdata[ppmfd_pkg::EXP_W-1:0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_gap_min      <= ppmfd_pkg::SYNC_GAP_RST;
            r_cfg.pulse_low_limit   <= ppmfd_pkg::PULSE_LOW_RST;
            r_cfg.pulse_high_limit  <= ppmfd_pkg::PULSE_HIGH_RST;
            r_cfg.expected_channels <= ppmfd_pkg::EXPECTED_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            ppmfd_pkg::REG_SYNC_GAP:   prdata = 32'(r_cfg.sync_gap_min);
            ppmfd_pkg::REG_PULSE_LOW:  prdata = 32'(r_cfg.pulse_low_limit);
            ppmfd_pkg::REG_PULSE_HIGH: prdata = 32'(r_cfg.pulse_high_limit);
            ppmfd_pkg::REG_EXPECTED:   prdata = 32'(r_cfg.expected_channels);
            default:                   prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/ppm_frame_decoder_core.sv @@
// ----------------------------------------------------------------------------
// ppm_frame_decoder_core
// RC PPM frame decoder: measures edge intervals, stores channel widths in a
// ring of cells and publishes a complete frame one channel item at a time.
// ----------------------------------------------------------------------------
// Sequence: an edge item is taken while the core is not busy; a publishing
// sync edge sets r_busy, then the output register loads the first channel
// item of the frame; later items follow in step order as the sink takes them.
// Throughput: one edge item per cycle while not busy; a publishing sync edge
// holds off input while the width ring makes one full rotation of MAX_CHANNELS (16) steps.
// Reset: synchronous, active low; clears the edge time, counter, busy flag, all
// widths and output valid, and loads the register reset values at once, with no clearing pass.
module ppm_frame_decoder_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    ppmfd_in_if.sink                           i_in,
    ppmfd_out_if.source                        o_out,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ppmfd_pkg::APB_AW-1:0]       paddr,
    input  logic [ppmfd_pkg::APB_DW-1:0]       pwdata,
    output logic [ppmfd_pkg::APB_DW-1:0]       prdata,
    output logic                               pready
);

    localparam int MC = ppmfd_pkg::MAX_CHANNELS;

    ppmfd_pkg::t_cfg                       cfg;
    ppmfd_pkg::t_cell_ctrl                 cell_ctrl;
    logic [ppmfd_pkg::WIDTH_W-1:0]         cell_width [MC];

    logic [ppmfd_pkg::TIME_W-1:0]          r_prev;
    logic [ppmfd_pkg::CNT_W-1:0]           r_cnt;
    logic                                  r_busy;
    logic [ppmfd_pkg::STEP_W-1:0]          r_step;
    logic                                  r_out_valid;
    logic [ppmfd_pkg::IDX_W-1:0]           r_out_idx;
    logic [ppmfd_pkg::WIDTH_W-1:0]         r_out_width;
    logic                                  r_out_last;

    logic                                  in_fire;
    logic [ppmfd_pkg::TIME_W-1:0]          delta;
    logic [ppmfd_pkg::WIDTH_W-1:0]         interval;
    logic                                  sync_gap;
    logic                                  in_window;
    logic                                  store_room;
    logic                                  publish;
    logic                                  emit_step;
    logic                                  slot_free;
    logic                                  advance;
    logic                                  last_step;
    logic [31:0]                           step_ext;

    // Registers
    ppmfd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Interval since the last edge, saturated to 16 bits
    assign in_fire  = i_in.valid && i_in.ready;
    assign delta    = i_in.edge_time - r_prev;
    assign interval = (|delta[ppmfd_pkg::TIME_W-1:ppmfd_pkg::WIDTH_W]) ?
                      '1 : delta[ppmfd_pkg::WIDTH_W-1:0];
    assign sync_gap = interval > cfg.sync_gap_min;
    assign in_window = (interval > cfg.pulse_low_limit) &&
                       (interval < cfg.pulse_high_limit);
    assign store_room = r_cnt < ppmfd_pkg::CNT_W'(MC);

    // Publish only a frame with exactly the expected, storable channel count
    assign publish = (ppmfd_pkg::CMP_W'(r_cnt) ==
                      ppmfd_pkg::CMP_W'(cfg.expected_channels)) &&
                     (32'(cfg.expected_channels) <= 32'(MC)) &&
                     (32'(cfg.expected_channels) <= 32'(ppmfd_pkg::RESULT_LIMIT)) &&
                     (cfg.expected_channels != '0);

    // Rotation: steps below the expected count emit an item and wait for room
    assign step_ext  = 32'(r_step);
    assign emit_step = r_busy && (step_ext < 32'(cfg.expected_channels));
    assign slot_free = !r_out_valid || o_out.ready;
    assign advance   = r_busy && (!emit_step || slot_free);
    assign last_step = r_step == ppmfd_pkg::STEP_W'(MC - 1);

    assign i_in.ready = !r_busy;

    // Ring control
    assign cell_ctrl.shift       = advance;
    assign cell_ctrl.store       = in_fire && !sync_gap && in_window && store_room;
    assign cell_ctrl.store_width = interval;

    // Row of width cells; each takes its right neighbour on rotate
    for (genvar g = 0; g < MC; g++) begin : g_cell
        ppmfd_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (cell_ctrl),
            .i_sel      (r_cnt == ppmfd_pkg::CNT_W'(g)),
            .i_shift_in (cell_width[(g + 1) % MC]),
            .o_width    (cell_width[g])
        );
    end

    // Edge tracking, channel counting and publish sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_step <= '0;
        end else begin
            if (in_fire) begin
                r_prev <= i_in.edge_time;
                if (sync_gap) begin
                    r_cnt <= '0;
                    if (publish) begin
                        r_busy <= 1'b1;
                        r_step <= '0;
                    end
                end else if (r_cnt < ppmfd_pkg::CNT_W'(MC + 1)) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (advance) begin
                r_step <= r_step + 1'b1;
                if (last_step) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Output register: hold until taken, load on each emitting step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_step && slot_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_step && slot_free) begin
            r_out_idx   <= step_ext[ppmfd_pkg::IDX_W-1:0];
            r_out_width <= cell_width[0];
            r_out_last  <= (step_ext + 32'd1) == 32'(cfg.expected_channels);
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.channel_index = r_out_idx;
    assign o_out.channel_width = r_out_width;
    assign o_out.frame_last    = r_out_last;

    // A publish starts only from a matching channel count and clears it
    a_publish_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> (ppmfd_pkg::CMP_W'($past(r_cnt)) ==
                           ppmfd_pkg::CMP_W'($past(cfg.expected_channels))) &&
                          (r_cnt == '0))
        else $error("publish started without a matching channel count");

    // The ring finishes only after a full rotation
    a_full_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> $past(r_step) == ppmfd_pkg::STEP_W'(MC - 1))
        else $error("ring rotation ended early");

    // Counter saturates one above the store depth
    a_cnt_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && !sync_gap && (r_cnt == ppmfd_pkg::CNT_W'(MC + 1))
        |=> r_cnt == ppmfd_pkg::CNT_W'(MC + 1))
        else $error("channel counter left saturation");

endmodule
